// ----- rtl/fskrx_pkg.sv -----
// fskrx_pkg: shared constants for the tone-pair frame receiver.
// No dependencies; imported by fsk_frame_receiver_core.
`default_nettype none

package fskrx_pkg;

  localparam int DATA_BITS   = 8;
  localparam int BITS_LEFT_W = 6;
  localparam int CFG_W       = 8;
  localparam int DATA_W      = 8;

  // configuration register indexes
  localparam logic REG_SAMPLES_PER_BIT = 1'b0;
  localparam logic REG_MIN_SAMPLES     = 1'b1;

  localparam logic [CFG_W-1:0] SAMPLES_PER_BIT_RST = 8'd16;
  localparam logic [CFG_W-1:0] MIN_SAMPLES_RST     = 8'd10;

endpackage

`default_nettype wire

// ----- rtl/fsk_frame_receiver_core.sv -----
// Usage notes for the tone-pair frame receiver (top level).
// Depends on fskrx_pkg.
//
// Input channel (in_valid/in_ready): one word per detector sample,
//   det_low and det_high. Low only is symbol 0, high only is symbol 1.
// Output channel (out_valid/out_ready): exactly one word per input word,
//   frame_valid and frame_data. frame_valid is 1 only on the word whose stop
//   bit completes a frame with good parity; frame_data is 0 otherwise.
// Config: cfg_we writes cfg_wdata into samples_per_bit (index 0) or
//   min_samples (index 1); write only while no words are in flight.
// Result: the result of a sample is registered at accept.
// Throughput: one sample per cycle while in_ready is high; the frame state updates
//   in one pass at accept, and a result register plus a one-word skid buffer decouple
//   the two channels.
// Stall: with the result register and skid buffer both full, in_ready drops
//   until out_ready takes a word.
// Reset (rst, synchronous): receiver idle, registers back to 16 and 10,
//   both output stages empty.
`default_nettype none

module fsk_frame_receiver_core
  import fskrx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_addr,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              det_low,
  input  wire logic              det_high,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   frame_valid,
  output logic [DATA_W-1:0]      frame_data
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_PARITY = 3'd3;
  localparam logic [2:0] PH_STOP   = 3'd4;

  logic [CFG_W-1:0]       samples_per_bit;
  logic [CFG_W-1:0]       min_samples;

  logic [2:0]             frame_phase,  frame_phase_next;
  logic [7:0]             window_timer, window_timer_next;
  logic [7:0]             low_count,    low_count_next;
  logic [7:0]             high_count,   high_count_next;
  logic [BITS_LEFT_W-1:0] bits_left,    bits_left_next;
  logic                   ones_parity,  ones_parity_next;
  logic [DATA_W-1:0]      data_shift,   data_shift_next;

  logic                   res_valid;
  logic [DATA_W-1:0]      res_data;

  logic                   skid_vld;
  logic                   skid_fv;
  logic [DATA_W-1:0]      skid_data;

  logic sym0, sym1, in_fire;
  logic [7:0] timer_inc, low_inc, high_inc;
  logic [BITS_LEFT_W-1:0] bits_dec;
  logic win_end, got_low, got_high, bit_val;

  assign sym0     = det_low & ~det_high;
  assign sym1     = det_high & ~det_low;
  assign in_ready = ~skid_vld;
  assign in_fire  = in_valid & in_ready;

  assign timer_inc = window_timer + 8'd1;
  assign low_inc   = low_count + {7'd0, sym0};
  assign high_inc  = high_count + {7'd0, sym1};
  assign win_end   = timer_inc >= samples_per_bit;
  assign got_low   = low_inc >= min_samples;
  assign got_high  = high_inc >= min_samples;
  assign bit_val   = ~got_low;
  assign bits_dec  = bits_left - BITS_LEFT_W'(1);

  always_comb begin
    frame_phase_next  = frame_phase;
    window_timer_next = window_timer;
    low_count_next    = low_count;
    high_count_next   = high_count;
    bits_left_next    = bits_left;
    ones_parity_next  = ones_parity;
    data_shift_next   = data_shift;
    res_valid         = 1'b0;
    res_data          = '0;
    if (frame_phase == PH_START || frame_phase == PH_DATA ||
        frame_phase == PH_PARITY || frame_phase == PH_STOP) begin
      window_timer_next = timer_inc;
      low_count_next    = low_inc;
      high_count_next   = high_inc;
    end
    unique case (frame_phase)
      PH_START: begin
        if (win_end) begin
          frame_phase_next = got_low ? PH_DATA : PH_IDLE;
          if (got_low) begin
            window_timer_next = '0;
            low_count_next    = '0;
            high_count_next   = '0;
          end
        end
      end
      PH_DATA: begin
        if (win_end) begin
          if (got_low || got_high) begin
            data_shift_next   = {data_shift[DATA_W-2:0], bit_val};
            ones_parity_next  = ones_parity ^ bit_val;
            bits_left_next    = bits_dec;
            frame_phase_next  = (bits_dec == '0) ? PH_PARITY : PH_DATA;
            window_timer_next = '0;
            low_count_next    = '0;
            high_count_next   = '0;
          end else begin
            frame_phase_next = PH_IDLE;
          end
        end
      end
      PH_PARITY: begin
        if (win_end) begin
          if (ones_parity ? got_high : got_low) begin
            frame_phase_next  = PH_STOP;
            window_timer_next = '0;
            low_count_next    = '0;
            high_count_next   = '0;
          end else begin
            frame_phase_next = PH_IDLE;
          end
        end
      end
      PH_STOP: begin
        if (win_end) begin
          frame_phase_next = PH_IDLE;
          res_valid        = got_low;
          res_data         = got_low ? data_shift : '0;
        end
      end
      default: begin
        // idle and unused codes
        frame_phase_next = PH_IDLE;
        if (sym0) begin
          frame_phase_next  = PH_START;
          window_timer_next = 8'd1;
          low_count_next    = 8'd1;
          high_count_next   = '0;
          bits_left_next    = BITS_LEFT_W'(DATA_BITS);
          ones_parity_next  = 1'b0;
          data_shift_next   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_bit <= SAMPLES_PER_BIT_RST;
      min_samples     <= MIN_SAMPLES_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLES_PER_BIT: samples_per_bit <= cfg_wdata;
        REG_MIN_SAMPLES:     min_samples     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase  <= PH_IDLE;
      window_timer <= '0;
      low_count    <= '0;
      high_count   <= '0;
      bits_left    <= '0;
      ones_parity  <= 1'b0;
      data_shift   <= '0;
    end else if (in_fire) begin
      frame_phase  <= frame_phase_next;
      window_timer <= window_timer_next;
      low_count    <= low_count_next;
      high_count   <= high_count_next;
      bits_left    <= bits_left_next;
      ones_parity  <= ones_parity_next;
      data_shift   <= data_shift_next;
    end
  end

  // result register with one-word skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_vld) begin
          out_valid <= 1'b1;
          skid_vld  <= in_fire;
        end else begin
          out_valid <= in_fire;
        end
      end else if (in_fire) begin
        skid_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_vld) begin
        frame_valid <= skid_fv;
        frame_data  <= skid_data;
      end else if (in_fire) begin
        frame_valid <= res_valid;
        frame_data  <= res_data;
      end
    end
    if (in_fire && (skid_vld || (out_valid && !out_ready))) begin
      skid_fv   <= res_valid;
      skid_data <= res_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fskrx_checker.sv -----
// fskrx_checker: port-level checks for fsk_frame_receiver_core, plus its bind.
// Depends on fskrx_pkg.
`default_nettype none

module fskrx_checker
  import fskrx_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              frame_valid,
  input wire logic [DATA_W-1:0] frame_data
);

  // every accepted word produces a result word
  a_word_yields_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word left no result");

  // input back-pressure only while the output is backed up
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  a_data_zero_no_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |-> frame_data == '0)
    else $error("frame_data nonzero without frame");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_valid) && $stable(frame_data))
    else $error("result changed while stalled");

endmodule

bind fsk_frame_receiver_core fskrx_checker u_fskrx_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .frame_valid (frame_valid),
  .frame_data  (frame_data)
);

`default_nettype wire

// ----- tb/fsk_frame_receiver_core_tb.sv -----
// Self-checking testbench for fsk_frame_receiver_core: drives tone-flag samples and
// compares every output word against an in-bench frame decoder.
// Depends on fskrx_pkg and the RTL of fsk_frame_receiver_core.
`default_nettype none

module fsk_frame_receiver_core_tb;
  import fskrx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {PH_IDLE, PH_START, PH_DATA, PH_PARITY, PH_STOP} rx_phase_t;
  typedef enum int {FLAW_NONE, FLAW_PARITY, FLAW_STOP, FLAW_CUT} flaw_t;

  typedef struct packed {
    logic lo;
    logic hi;
  } sample_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } rx_frame_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_addr = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              det_low = 1'b0;
  logic              det_high = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              frame_valid;
  logic [DATA_W-1:0] frame_data;

  fsk_frame_receiver_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .det_low(det_low), .det_high(det_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_valid(frame_valid), .frame_data(frame_data)
  );

  always #1 clk = ~clk;

  // decoder state and register mirror
  rx_phase_t               rx_phase = PH_IDLE;
  logic [7:0]              win_cnt = '0;
  logic [7:0]              zero_cnt = '0;
  logic [7:0]              one_cnt = '0;
  logic [BITS_LEFT_W-1:0]  bits_left = '0;
  logic                    par_acc = 1'b0;
  logic [DATA_W-1:0]       shift_reg = '0;
  logic [CFG_W-1:0]        spb_r = SAMPLES_PER_BIT_RST;
  logic [CFG_W-1:0]        thr_r = MIN_SAMPLES_RST;

  sample_t   samples_pending[$];
  rx_frame_t frames_due[$];

  int  queued_total = 0;
  int  accepted_total = 0;
  int  mismatches = 0;
  int  frames_seen = 0;
  int  input_stalls = 0;
  int  settings_used = 1;
  int  stall_cycles = 0;
  int  send_gap_pct = 0;
  int  recv_gap_pct = 0;
  int  hold_reqs = 0;
  int  hold_served = 0;
  int  hold_left = 0;
  logic in_took = 1'b0;

  function automatic void open_window(input rx_phase_t next);
    rx_phase = next;
    win_cnt  = '0;
    zero_cnt = '0;
    one_cnt  = '0;
  endfunction

  function automatic rx_frame_t decode_sample(input logic lo, input logic hi);
    logic      sym0, sym1, got_low, got_high, bitv;
    rx_frame_t res;
    sym0 = lo & ~hi;
    sym1 = hi & ~lo;
    res  = '0;
    if (rx_phase == PH_IDLE) begin
      if (sym0) begin
        rx_phase  = PH_START;
        win_cnt   = 8'd1;
        zero_cnt  = 8'd1;
        one_cnt   = '0;
        bits_left = BITS_LEFT_W'(DATA_BITS);
        par_acc   = 1'b0;
        shift_reg = '0;
      end
    end else begin
      win_cnt = win_cnt + 8'd1;
      if (sym0) zero_cnt = zero_cnt + 8'd1;
      if (sym1) one_cnt = one_cnt + 8'd1;
      if (win_cnt >= spb_r) begin
        got_low  = zero_cnt >= thr_r;
        got_high = one_cnt >= thr_r;
        case (rx_phase)
          PH_START: begin
            if (got_low) open_window(PH_DATA);
            else rx_phase = PH_IDLE;
          end
          PH_DATA: begin
            if (got_low || got_high) begin
              bitv      = ~got_low;
              shift_reg = {shift_reg[DATA_W-2:0], bitv};
              par_acc   = par_acc ^ bitv;
              bits_left = bits_left - 1'b1;
              open_window(bits_left == '0 ? PH_PARITY : PH_DATA);
            end else begin
              rx_phase = PH_IDLE;
            end
          end
          PH_PARITY: begin
            if (par_acc ? got_high : got_low) open_window(PH_STOP);
            else rx_phase = PH_IDLE;
          end
          default: begin
            res.valid = got_low;
            res.data  = got_low ? shift_reg : '0;
            rx_phase  = PH_IDLE;
          end
        endcase
      end
    end
    return res;
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  // sender
  always @(negedge clk) begin
    sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (samples_pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s = samples_pending.pop_front();
        in_valid <= 1'b1;
        det_low  <= s.lo;
        det_high <= s.hi;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_served < hold_reqs) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // monitor, decoder and watchdog
  always @(posedge clk) begin
    rx_frame_t want;
    in_took <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && !in_ready) input_stalls++;
      if (in_valid && in_ready) begin
        frames_due.push_back(decode_sample(det_low, det_high));
        accepted_total++;
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          flag_error($sformatf("word with nothing expected: valid %b data %h",
                               frame_valid, frame_data));
        end else begin
          want = frames_due.pop_front();
          if (frame_valid !== want.valid)
            flag_error($sformatf("frame_valid exp %b got %b", want.valid, frame_valid));
          if (frame_data !== want.data)
            flag_error($sformatf("frame_data exp %h got %h", want.data, frame_data));
          if (frame_valid === 1'b1) frames_seen++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic push_sample(input logic lo, input logic hi);
    sample_t s;
    s.lo = lo;
    s.hi = hi;
    samples_pending.push_back(s);
    queued_total++;
  endtask

  // one bit window: enough samples of the wanted symbol, the rest noise
  task automatic push_window(input logic sym, input int len, input logic lead0);
    int left_n, opp_n, r;
    left_n = (thr_r <= len) ? $urandom_range(len, thr_r) : len;
    opp_n  = 0;
    for (int i = 0; i < len; i++) begin
      if ((i == 0 && lead0) || $urandom_range(len - i - 1) < left_n) begin
        push_sample(~sym, sym);
        left_n--;
      end else begin
        r = $urandom_range(5);
        if (r == 0 && (!sym || opp_n + 1 < thr_r)) begin
          push_sample(sym, ~sym);
          opp_n++;
        end else begin
          push_sample(r[0], r[0]);
        end
      end
    end
  endtask

  task automatic push_frame(input logic [DATA_BITS-1:0] bits, input flaw_t flaw);
    int data_len, start_len, cut_at;
    data_len  = (spb_r > 1) ? spb_r : 1;
    start_len = (spb_r > 2) ? spb_r : 2;
    cut_at    = (flaw == FLAW_CUT) ? $urandom_range(DATA_BITS - 1) : DATA_BITS;
    push_window(1'b0, start_len, 1'b1);
    for (int i = 0; i < DATA_BITS; i++) begin
      if (i == cut_at) begin
        repeat (2 * data_len) push_sample(1'b0, 1'b0);
        return;
      end
      push_window(bits[DATA_BITS-1-i], data_len, 1'b0);
    end
    push_window((^bits) ^ (flaw == FLAW_PARITY), data_len, 1'b0);
    push_window(flaw == FLAW_STOP, data_len, 1'b0);
  endtask

  task automatic run_random(input int budget);
    int first, r;
    first = queued_total;
    while (queued_total - first < budget) begin
      r = $urandom_range(99);
      if (r < 70)      push_frame(DATA_BITS'($urandom), FLAW_NONE);
      else if (r < 78) push_frame(DATA_BITS'($urandom), FLAW_PARITY);
      else if (r < 85) push_frame(DATA_BITS'($urandom), FLAW_STOP);
      else if (r < 92) push_frame(DATA_BITS'($urandom), FLAW_CUT);
      else repeat ($urandom_range(12, 1))
        push_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
      // line idle between frames: no symbol 0
      repeat ($urandom_range(3)) push_sample(1'b0, 1'($urandom_range(1)));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(accepted_total == queued_total && frames_due.size() == 0));
    repeat (3) @(negedge clk);
  endtask

  task automatic set_mode(input logic [CFG_W-1:0] spb, input logic [CFG_W-1:0] thr);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SAMPLES_PER_BIT;
    cfg_wdata <= spb;
    @(negedge clk);
    cfg_addr  <= REG_MIN_SAMPLES;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
    spb_r = spb;
    thr_r = thr;
    settings_used++;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    send_gap_pct = 13;
    recv_gap_pct = 77;
    push_frame(DATA_BITS'($urandom), FLAW_NONE);

    // samples_per_bit of zero; MSB-only data, then a parity error
    set_mode(8'd0, 8'd1);
    push_frame(8'h80, FLAW_NONE);
    push_frame(8'hFF, FLAW_PARITY);

    // zero threshold: every bit reads low whatever the tones
    set_mode(8'd1, 8'd0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b0, 1'b1);
    push_sample(1'b1, 1'b0);
    for (int i = 0; i < 11; i++) push_sample(i % 3 == 2, i % 3 != 0);

    set_mode(8'd2, 8'd1);
    run_random(40);
    set_mode(8'd4, 8'd3);
    run_random(40);

    send_gap_pct = 77;
    recv_gap_pct = 13;
    set_mode(8'd3, 8'd2);
    run_random(40);
    @(posedge clk);
    hold_reqs++;
    set_mode(8'd8, 8'd8);
    run_random(50);
    set_mode(8'd5, 8'd255);
    run_random(20);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_mode(8'd1, 8'd1);
    run_random(30);
    // widest window: a lone start symbol, then silence until the window closes
    set_mode(8'd255, 8'd255);
    push_sample(1'b1, 1'b0);
    repeat (254) push_sample(1'b0, 1'b0);
    set_mode(8'd6, 8'd4);
    run_random(40);

    wait_idle();
    $display("Run covered %0d samples under %0d register settings: %0d frames decoded,",
             accepted_total, settings_used, frames_seen);
    $display("%0d input stall cycles, %0d mismatches", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/fskrx_pkg.sv
rtl/fsk_frame_receiver_core.sv
rtl/fskrx_checker.sv
tb/fsk_frame_receiver_core_tb.sv
